// ----- hw/rtl/rltok_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the RTSP line tokenizer.
// No dependencies; imported by rltok_step and rtsp_line_tokenizer_unit.
package rltok_pkg;

  localparam int COUNT_BITS = 12;
  localparam int TCNT_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int RES_MAX    = 3;
  localparam int RES_N_W    = $clog2(RES_MAX + 1);
  localparam int QDEPTH     = 4;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CTRL_MAX = 8'h1F;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              token_end;
    logic              line_done;
    logic [TCNT_W-1:0] token_count;
    logic              last;
  } rltok_res_t;

  typedef struct packed {
    logic                  in_quotes;
    logic                  after_backslash;
    logic                  token_open;
    logic [COUNT_BITS-1:0] tokens_seen;
  } rltok_state_t;

  function automatic rltok_res_t mk_res(input logic [BYTE_W-1:0] data,
                                        input logic tend,
                                        input logic done,
                                        input logic [TCNT_W-1:0] cnt);
    rltok_res_t r;
    r.data        = data;
    r.token_end   = tend;
    r.line_done   = done;
    r.token_count = cnt;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ----- hw/rtl/rltok_step.sv -----
`timescale 1ns / 1ps
// Per-item decode of the tokenizer: results and next state for one byte.
// Depends on rltok_pkg.
module rltok_step (
  input  logic [7:0]                  in_byte,
  input  logic                        in_line_end,
  input  rltok_pkg::rltok_state_t     state_i,
  output rltok_pkg::rltok_state_t     state_o,
  output rltok_pkg::rltok_res_t       res_o [rltok_pkg::RES_MAX],
  output logic [rltok_pkg::RES_N_W-1:0] res_n
);
  import rltok_pkg::*;

  localparam int CW = COUNT_BITS + TCNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TCNT_W-1:0]     TCNT_MAX  = {TCNT_W{1'b1}};

  logic [COUNT_BITS-1:0] seen1;
  logic [COUNT_BITS-1:0] seen2;
  logic                  esc_ok;
  logic [BYTE_W-1:0]     esc_code;
  logic                  is_sep;
  logic                  is_blank;

  function automatic logic [TCNT_W-1:0] sat_cnt(input logic [COUNT_BITS-1:0] v);
    logic [CW-1:0] w;
    w = {{TCNT_W{1'b0}}, v};
    if (w > CW'(TCNT_MAX)) begin
      return TCNT_MAX;
    end
    return w[TCNT_W-1:0];
  endfunction

  assign seen1 = (state_i.tokens_seen == COUNT_MAX) ? state_i.tokens_seen
                                                    : state_i.tokens_seen + 1'b1;
  assign seen2 = (seen1 == COUNT_MAX) ? seen1 : seen1 + 1'b1;

  assign is_sep = in_byte inside {"(", ")", "[", "]", "{", "}", "<", ">",
                                  "@", ",", ";", ":", CH_BSLASH, "/", "?", "="};
  assign is_blank = (in_byte == CH_SPACE) || (in_byte <= CH_CTRL_MAX) ||
                    (in_byte == CH_DEL);

  always_comb begin
    esc_ok   = 1'b1;
    esc_code = in_byte;
    case (in_byte)
      CH_BSLASH: esc_code = CH_BSLASH;
      CH_QUOTE:  esc_code = CH_QUOTE;
      "n":       esc_code = 8'h0A;
      "r":       esc_code = 8'h0D;
      "t":       esc_code = 8'h09;
      "a":       esc_code = 8'h07;
      "f":       esc_code = 8'h0C;
      "v":       esc_code = 8'h0B;
      "b":       esc_code = 8'h08;
      "e":       esc_code = 8'h1B;
      "0":       esc_ok   = 1'b0;
      CH_NUL:    esc_ok   = 1'b0;
      default:   esc_code = in_byte;
    endcase
  end

  always_comb begin
    state_o = state_i;
    res_n   = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      res_o[i] = mk_res('0, 1'b0, 1'b0, '0);
    end

    if (in_line_end) begin
      if (state_i.token_open) begin
        res_o[0] = mk_res('0, 1'b1, 1'b0, '0);
        res_o[1] = mk_res('0, 1'b0, 1'b1, sat_cnt(seen1));
        res_n    = RES_N_W'(2);
      end else begin
        res_o[0] = mk_res('0, 1'b0, 1'b1, sat_cnt(state_i.tokens_seen));
        res_n    = RES_N_W'(1);
      end
      state_o = '0;
    end else if (state_i.in_quotes) begin
      if (state_i.after_backslash) begin
        if (esc_ok) begin
          res_o[0] = mk_res(esc_code, 1'b0, 1'b0, '0);
          res_n    = RES_N_W'(1);
        end
        state_o.after_backslash = 1'b0;
        state_o.token_open      = 1'b1;
      end else if (in_byte == CH_QUOTE) begin
        res_o[0]            = mk_res('0, 1'b1, 1'b0, '0);
        res_n               = RES_N_W'(1);
        state_o.tokens_seen = seen1;
        state_o.in_quotes   = 1'b0;
        state_o.token_open  = 1'b0;
      end else if (in_byte == CH_BSLASH) begin
        state_o.after_backslash = 1'b1;
        state_o.token_open      = 1'b1;
      end else if (in_byte != CH_NUL) begin
        res_o[0]           = mk_res(in_byte, 1'b0, 1'b0, '0);
        res_n              = RES_N_W'(1);
        state_o.token_open = 1'b1;
      end
    end else if (in_byte == CH_QUOTE) begin
      if (state_i.token_open) begin
        res_o[0]            = mk_res('0, 1'b1, 1'b0, '0);
        res_n               = RES_N_W'(1);
        state_o.tokens_seen = seen1;
      end
      state_o.in_quotes       = 1'b1;
      state_o.after_backslash = 1'b0;
      state_o.token_open      = 1'b0;
    end else if (is_sep) begin
      if (state_i.token_open) begin
        res_o[0]            = mk_res('0, 1'b1, 1'b0, '0);
        res_o[1]            = mk_res(in_byte, 1'b0, 1'b0, '0);
        res_o[2]            = mk_res('0, 1'b1, 1'b0, '0);
        res_n               = RES_N_W'(3);
        state_o.tokens_seen = seen2;
      end else begin
        res_o[0]            = mk_res(in_byte, 1'b0, 1'b0, '0);
        res_o[1]            = mk_res('0, 1'b1, 1'b0, '0);
        res_n               = RES_N_W'(2);
        state_o.tokens_seen = seen1;
      end
      state_o.token_open = 1'b0;
    end else if (is_blank) begin
      if (state_i.token_open) begin
        res_o[0]            = mk_res('0, 1'b1, 1'b0, '0);
        res_n               = RES_N_W'(1);
        state_o.tokens_seen = seen1;
      end
      state_o.token_open = 1'b0;
    end else begin
      res_o[0]           = mk_res(in_byte, 1'b0, 1'b0, '0);
      res_n              = RES_N_W'(1);
      state_o.token_open = 1'b1;
    end

    for (int i = 0; i < RES_MAX; i++) begin
      res_o[i].last = (RES_N_W'(i) + RES_N_W'(1) == res_n);
    end
  end

endmodule

// ----- hw/rtl/rtsp_line_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the RTSP line tokenizer: state registers and result queue.
// Depends on rltok_pkg and rltok_step.

// The tokenizer takes one character (or a line-end marker) per item and
// emits token bytes, token ends and a final count result on the output
// channel, one result per cycle while out_ready is high. An item is decoded
// in the cycle it is accepted and its zero to three results go into a
// four-entry result queue; a new item is accepted whenever the queue has
// room for three more results, so input items that cause at most one
// result flow at one item per cycle while the consumer takes every result,
// and a single result held by a stalled consumer does not block the next
// item. Throughput is set by the single output port draining that queue;
// the most results, three, come from a separator closing an open token.
module rtsp_line_tokenizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_token_end,
  output logic        out_line_done,
  output logic [11:0] out_token_count,
  output logic        out_last
);
  import rltok_pkg::*;

  rltok_state_t          state_r;
  rltok_state_t          state_nxt;
  rltok_res_t            step_res [RES_MAX];
  logic [RES_N_W-1:0]    step_n;
  rltok_res_t            q_r   [QDEPTH];
  rltok_res_t            q_nxt [QDEPTH];
  rltok_res_t            q_sh  [QDEPTH];
  logic [QCNT_W-1:0]     qcnt_r;
  logic [QCNT_W-1:0]     qcnt_nxt;
  logic [QCNT_W-1:0]     base;
  logic                  pop;
  logic                  acc;

  rltok_step u_step (
    .in_byte     (in_byte),
    .in_line_end (in_line_end),
    .state_i     (state_r),
    .state_o     (state_nxt),
    .res_o       (step_res),
    .res_n       (step_n)
  );

  assign out_valid = (qcnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign base      = qcnt_r - QCNT_W'(pop);
  assign in_ready  = (base <= QCNT_W'(QDEPTH - RES_MAX));
  assign acc       = in_valid & in_ready;

  always_comb begin
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_sh[i] = pop ? q_r[i + 1] : q_r[i];
    end
    q_sh[QDEPTH-1] = q_r[QDEPTH-1];

    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_sh[i];
      for (int k = 0; k < RES_MAX; k++) begin
        if (acc && (RES_N_W'(k) < step_n) &&
            (base + QCNT_W'(k) == QCNT_W'(i))) begin
          q_nxt[i] = step_res[k];
        end
      end
    end

    qcnt_nxt = base + (acc ? QCNT_W'(step_n) : QCNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r  <= '0;
      state_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (acc) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_byte        = q_r[0].data;
  assign out_token_end   = q_r[0].token_end;
  assign out_line_done   = q_r[0].line_done;
  assign out_token_count = q_r[0].token_count;
  assign out_last        = q_r[0].last;

endmodule

// ----- tb/rtsp_line_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rtsp_line_tokenizer_unit: directed rows and random lines,
// checked against fixed expected results or an in-bench tokenizer.
// Depends on rltok_pkg and the tokenizer RTL.
module rtsp_line_tokenizer_unit_tb;
  import rltok_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic [7:0] c;
    logic       le;
    logic       fixed;
    rltok_res_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_line_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_token_end;
  logic        out_line_done;
  logic [11:0] out_token_count;
  logic        out_last;

  rtsp_line_tokenizer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_token_end   (out_token_end),
    .out_line_done   (out_line_done),
    .out_token_count (out_token_count),
    .out_last        (out_last)
  );

  rltok_res_t      results_due [$];
  row_t            plan [$];
  rltok_res_t      step_res [3];
  int              step_n;
  int              errors;
  int              sent;
  int              quiet_cycles;
  logic            live;
  logic            calm;
  string           seps;

  logic            in_q;
  logic            after_bs;
  logic            tok_open;
  logic [11:0]     seen;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic rltok_res_t one_result(input logic [7:0] d, input logic te,
                                            input logic ld, input logic [11:0] cnt);
    rltok_res_t r;
    r.data        = d;
    r.token_end   = te;
    r.line_done   = ld;
    r.token_count = cnt;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] c, input logic le, input logic fixed,
                                  input logic [7:0] d, input logic te, input logic ld,
                                  input logic [11:0] cnt);
    row_t r;
    r.c     = c;
    r.le    = le;
    r.fixed = fixed;
    r.want  = one_result(d, te, ld, cnt);
    plan.push_back(r);
  endfunction

  function automatic void emit(input logic [7:0] d, input logic te, input logic ld,
                               input logic [11:0] cnt);
    step_res[step_n] = one_result(d, te, ld, cnt);
    step_res[step_n].last = 1'b0;
    step_n++;
  endfunction

  function automatic void close_token();
    if (seen != 12'hFFF) seen = seen + 12'd1;
    emit(8'h00, 1'b1, 1'b0, 12'd0);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    case (c)
      "(", ")", "[", "]", "{", "}", "<", ">",
      "@", ",", ";", ":", "\\", "/", "?", "=": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int escape_of(input logic [7:0] c);
    case (c)
      "\\": return 'h5C;
      "\"": return 'h22;
      "n": return 'h0A;
      "r": return 'h0D;
      "t": return 'h09;
      "a": return 'h07;
      "f": return 'h0C;
      "v": return 'h0B;
      "b": return 'h08;
      "e": return 'h1B;
      "0", 8'h00: return -1;
      default: return int'(c);
    endcase
  endfunction

  function automatic void tokenize(input logic [7:0] c, input logic le);
    int esc;
    step_n = 0;
    if (le) begin
      if (tok_open) close_token();
      emit(8'h00, 1'b0, 1'b1, seen);
      in_q = 1'b0;
      after_bs = 1'b0;
      tok_open = 1'b0;
      seen = '0;
    end else if (in_q) begin
      if (after_bs) begin
        esc = escape_of(c);
        if (esc >= 0) emit(esc[7:0], 1'b0, 1'b0, 12'd0);
        after_bs = 1'b0;
        tok_open = 1'b1;
      end else if (c == CH_QUOTE) begin
        close_token();
        in_q = 1'b0;
        tok_open = 1'b0;
      end else if (c == CH_BSLASH) begin
        after_bs = 1'b1;
        tok_open = 1'b1;
      end else if (c != CH_NUL) begin
        emit(c, 1'b0, 1'b0, 12'd0);
        tok_open = 1'b1;
      end
    end else if (c == CH_QUOTE) begin
      if (tok_open) close_token();
      in_q = 1'b1;
      after_bs = 1'b0;
      tok_open = 1'b0;
    end else if (is_sep(c)) begin
      if (tok_open) close_token();
      emit(c, 1'b0, 1'b0, 12'd0);
      close_token();
      tok_open = 1'b0;
    end else if (c == CH_SPACE || c <= CH_CTRL_MAX || c == CH_DEL) begin
      if (tok_open) close_token();
      tok_open = 1'b0;
    end else begin
      emit(c, 1'b0, 1'b0, 12'd0);
      tok_open = 1'b1;
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (roll < 38) return 8'($urandom_range(128, 255));
    if (roll < 46) return CH_SPACE;
    if (roll < 52) return ($urandom_range(0, 3) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
    if (roll < 64) return seps[$urandom_range(0, 15)];
    if (roll < 74) return CH_QUOTE;
    if (roll < 84) return CH_BSLASH;
    if (roll < 90) return "0";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(input logic [7:0] c, input logic le, input logic fixed,
                      input rltok_res_t want);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_byte     = c;
    in_line_end = le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize(c, le);
    if (fixed) results_due.push_back(want);
    else for (int i = 0; i < step_n; i++) results_due.push_back(step_res[i]);
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (live) out_ready = calm || ($urandom_range(0, 99) >= 20);
  end

  function automatic void note(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin
    rltok_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t unexpected item: byte %0h end %0b done %0b count %0d last %0b",
                 $time, out_byte, out_token_end, out_line_done, out_token_count, out_last);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_byte !== want.data) note("out_byte", want.data, out_byte);
        if (out_token_end !== want.token_end)
          note("out_token_end", want.token_end, out_token_end);
        if (out_line_done !== want.line_done)
          note("out_line_done", want.line_done, out_line_done);
        if (out_token_count !== want.token_count)
          note("out_token_count", want.token_count, out_token_count);
        if (out_last !== want.last) note("out_last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (live) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no progress, %0d items still due", $time,
                 results_due.size());
        $display("[rtsp_line_tokenizer_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rltok_res_t none;
    int len;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    in_line_end = 1'b0;
    out_ready = 1'b0;
    errors = 0;
    sent = 0;
    quiet_cycles = 0;
    live = 1'b0;
    calm = 1'b0;
    seps = "()[]{}<>@,;:\\/?=";
    none = one_result(8'h00, 1'b0, 1'b0, 12'd0);
    in_q = 1'b0;
    after_bs = 1'b0;
    tok_open = 1'b0;
    seen = '0;

    add_row(8'h00,    1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 12'd0);
    add_row("A",      1'b0, 1'b1, 8'h41, 1'b0, 1'b0, 12'd0);
    add_row(8'hFF,    1'b0, 1'b1, 8'hFF, 1'b0, 1'b0, 12'd0);
    add_row(8'h80,    1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 12'd0);
    add_row("(",      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_SPACE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("x",      1'b0, 1'b1, 8'h78, 1'b0, 1'b0, 12'd0);
    add_row(CH_DEL,   1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 12'd0);
    add_row("q",      1'b0, 1'b1, 8'h71, 1'b0, 1'b0, 12'd0);
    add_row(CH_NUL,   1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("\\",     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("n",      1'b0, 1'b1, 8'h0A, 1'b0, 1'b0, 12'd0);
    add_row("\\",     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("0",      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("\\",     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_NUL,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_NUL,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("\\",     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(8'hA5,    1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row("z",      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);
    add_row(8'h5A,    1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 12'd0);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    live = 1'b1;

    foreach (plan[i]) send(plan[i].c, plan[i].le, plan[i].fixed, plan[i].want);

    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 80 && sent < 140);
      len = $urandom_range(0, 14);
      for (int k = 0; k < len; k++) send(pick_byte(), 1'b0, 1'b0, none);
      send(8'($urandom_range(0, 255)), 1'b1, 1'b0, none);
    end
    calm = 1'b0;

    in_valid = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("[rtsp_line_tokenizer_unit] OK");
    end else begin
      $display("[rtsp_line_tokenizer_unit] ERROR");
    end
    $finish;
  end

endmodule
